// ===== hw/rtl/nrte_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor package
// Shared result type, character constants and helper functions.
// ----------------------------------------------------------------------------
package nrte_pkg;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_ACTIVE = 8'h41;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam int unsigned HEADER_LEN = 7;
    localparam int unsigned TIME_FIRST = 7;
    localparam int unsigned TIME_DIGITS = 6;
    localparam int unsigned STATUS_POS = 18;
    localparam logic [4:0]  POS_MAX = 5'd31;
    localparam logic [4:0]  ZONE_RESET = 5'd8;

    typedef struct packed {
        logic       sentence_accepted;
        logic       time_known;
        logic [4:0] local_hour;
        logic [6:0] minute_out;
        logic [6:0] second_out;
    } result_t;

    function automatic logic [7:0] header_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = 8'h24;
            5'd1:    c = 8'h47;
            5'd2:    c = 8'h50;
            5'd3:    c = 8'h52;
            5'd4:    c = 8'h4D;
            5'd5:    c = 8'h43;
            5'd6:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else
            v = 4'd0;
        return v;
    endfunction

    function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] units);
        return 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(units);
    endfunction

    // Input stays below 144, so three conditional subtractions suffice.
    function automatic logic [4:0] mod24(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd96)
            r = r - 8'd96;
        if (r >= 8'd48)
            r = r - 8'd48;
        if (r >= 8'd24)
            r = r - 8'd24;
        return r[4:0];
    endfunction

endpackage

// ===== hw/rtl/nrte_in_if.sv =====
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one sentence character per beat.
// ----------------------------------------------------------------------------
interface nrte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_line;

    modport source (output valid, output char_in, output end_of_line, input ready);
    modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

// ===== hw/rtl/nrte_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one line verdict and the held time per beat.
// ----------------------------------------------------------------------------
interface nrte_out_if;
    logic       valid;
    logic       ready;
    logic       sentence_accepted;
    logic       time_known;
    logic [4:0] local_hour;
    logic [6:0] minute_out;
    logic [6:0] second_out;

    modport source (output valid, output sentence_accepted, output time_known,
                    output local_hour, output minute_out, output second_out,
                    input ready);
    modport sink   (input valid, input sentence_accepted, input time_known,
                    input local_hour, input minute_out, input second_out,
                    output ready);
endinterface

// ===== hw/rtl/nrte_line_parser.sv =====
// ----------------------------------------------------------------------------
// Line parser
// Per-character header, checksum, status and time digit tracking, with the
// line verdict and held time formed on the final character of each line.
// ----------------------------------------------------------------------------
module nrte_line_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_in,
    input  logic                end_of_line,
    input  logic [4:0]          zone_offset,
    output logic                push,
    output nrte_pkg::result_t   push_data
);

    localparam logic [1:0] PHASE_CONTENT = 2'd0;
    localparam logic [1:0] PHASE_HIGH    = 2'd1;
    localparam logic [1:0] PHASE_LOW     = 2'd2;
    localparam logic [1:0] PHASE_DONE    = 2'd3;

    logic [4:0] pos_reg, pos_next;
    logic       hdr_reg, hdr_next;
    logic [7:0] xor_reg, xor_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] rsum_reg, rsum_next;
    logic       status_reg, status_next;
    logic       dvalid_reg, dvalid_next;
    logic [3:0] pend_reg [nrte_pkg::TIME_DIGITS];
    logic [3:0] pend_next [nrte_pkg::TIME_DIGITS];
    logic [3:0] held_reg [nrte_pkg::TIME_DIGITS];
    logic [3:0] held_next [nrte_pkg::TIME_DIGITS];
    logic       known_reg, known_next;
    logic       ok;
    logic       is_digit;

    assign is_digit = (char_in >= nrte_pkg::CHAR_ZERO) && (char_in <= nrte_pkg::CHAR_NINE);

    always_comb
    begin
        hdr_next    = hdr_reg;
        xor_next    = xor_reg;
        phase_next  = phase_reg;
        rsum_next   = rsum_reg;
        status_next = status_reg;
        dvalid_next = dvalid_reg;
        pend_next   = pend_reg;

        if (pos_reg < 5'(nrte_pkg::HEADER_LEN) && char_in != nrte_pkg::header_char(pos_reg))
            hdr_next = 1'b0;

        if (pos_reg != 5'd0)
        begin
            case (phase_reg)
                PHASE_CONTENT:
                begin
                    if (char_in == nrte_pkg::CHAR_STAR)
                        phase_next = PHASE_HIGH;
                    else
                        xor_next = xor_reg ^ char_in;
                end
                PHASE_HIGH:
                begin
                    rsum_next  = {nrte_pkg::hex_value(char_in), 4'd0};
                    phase_next = PHASE_LOW;
                end
                PHASE_LOW:
                begin
                    rsum_next  = rsum_reg + {4'd0, nrte_pkg::hex_value(char_in)};
                    phase_next = PHASE_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        for (int i = 0; i < nrte_pkg::TIME_DIGITS; i++)
        begin
            if (pos_reg == 5'(nrte_pkg::TIME_FIRST + i))
            begin
                if (is_digit)
                    pend_next[i] = 4'(char_in - nrte_pkg::CHAR_ZERO);
                else
                    dvalid_next = 1'b0;
            end
        end

        if (pos_reg == 5'(nrte_pkg::STATUS_POS) && char_in == nrte_pkg::CHAR_ACTIVE)
            status_next = 1'b1;

        pos_next = (pos_reg < nrte_pkg::POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    assign ok = hdr_next && (xor_next == rsum_next) && status_next && dvalid_next;

    always_comb
    begin
        held_next  = held_reg;
        known_next = known_reg;
        if (end_of_line && ok)
        begin
            held_next  = pend_next;
            known_next = 1'b1;
        end
    end

    assign push = accept && end_of_line;

    always_comb
    begin
        push_data.sentence_accepted = ok;
        push_data.time_known        = known_next;
        push_data.local_hour        = nrte_pkg::mod24(
            8'(nrte_pkg::two_digits(held_next[0], held_next[1])) + {3'd0, zone_offset});
        push_data.minute_out        = nrte_pkg::two_digits(held_next[2], held_next[3]);
        push_data.second_out        = nrte_pkg::two_digits(held_next[4], held_next[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 5'd0;
            hdr_reg    <= 1'b1;
            xor_reg    <= 8'd0;
            phase_reg  <= PHASE_CONTENT;
            rsum_reg   <= 8'd0;
            status_reg <= 1'b0;
            dvalid_reg <= 1'b1;
            known_reg  <= 1'b0;
            for (int i = 0; i < nrte_pkg::TIME_DIGITS; i++)
            begin
                pend_reg[i] <= 4'd0;
                held_reg[i] <= 4'd0;
            end
        end
        else if (accept)
        begin
            known_reg <= known_next;
            held_reg  <= held_next;
            if (end_of_line)
            begin
                pos_reg    <= 5'd0;
                hdr_reg    <= 1'b1;
                xor_reg    <= 8'd0;
                phase_reg  <= PHASE_CONTENT;
                rsum_reg   <= 8'd0;
                status_reg <= 1'b0;
                dvalid_reg <= 1'b1;
                for (int i = 0; i < nrte_pkg::TIME_DIGITS; i++)
                    pend_reg[i] <= 4'd0;
            end
            else
            begin
                pos_reg    <= pos_next;
                hdr_reg    <= hdr_next;
                xor_reg    <= xor_next;
                phase_reg  <= phase_next;
                rsum_reg   <= rsum_next;
                status_reg <= status_next;
                dvalid_reg <= dvalid_next;
                pend_reg   <= pend_next;
            end
        end
    end

endmodule

// ===== hw/rtl/nrte_result_buffer.sv =====
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output register that decouples the result channel from the
// character channel.
// ----------------------------------------------------------------------------
module nrte_result_buffer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nrte_pkg::result_t  push_data,
    output logic               full,
    nrte_out_if.source         result
);

    nrte_pkg::result_t slot0_reg, slot0_next;
    nrte_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop  = result.valid && result.ready;
    assign full = (count_reg == 2'd2);

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                    slot0_next = push_data;
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                    count_next = 2'd0;
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign result.valid             = (count_reg != 2'd0);
    assign result.sentence_accepted = slot0_reg.sentence_accepted;
    assign result.time_known        = slot0_reg.time_known;
    assign result.local_hour        = slot0_reg.local_hour;
    assign result.minute_out        = slot0_reg.minute_out;
    assign result.second_out        = slot0_reg.second_out;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("Result buffer count out of range.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("Result pushed into a full buffer.");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> result.valid)
        else $error("Pushed result did not appear on the output.");

endmodule

// ===== hw/rtl/nmea_rmc_time_extractor.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC time extractor
// Checks RMC sentences character by character and reports the verdict and
// the held local time at every line end.
// ----------------------------------------------------------------------------
// Throughput: one character beat per cycle while the result buffer has a free entry.
// The result of a line-end beat is registered in the result buffer before it is offered.
// A two-entry result buffer absorbs output stalls; input stalls only when
// both entries are occupied.
// Reset clears the line state, the held time and the buffer; the zone
// offset returns to eight hours.
// ----------------------------------------------------------------------------
module nmea_rmc_time_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    nrte_in_if.sink     sentence,
    nrte_out_if.source  result
);

    logic [4:0]        zone_reg;
    logic              accept;
    logic              push;
    logic              full;
    nrte_pkg::result_t push_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zone_reg <= nrte_pkg::ZONE_RESET;
        else if (cfg_we)
            zone_reg <= cfg_wdata;
    end

    assign sentence.ready = !full;
    assign accept         = sentence.valid && sentence.ready;

    nrte_line_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_in     (sentence.char_in),
        .end_of_line (sentence.end_of_line),
        .zone_offset (zone_reg),
        .push        (push),
        .push_data   (push_data)
    );

    nrte_result_buffer u_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .result    (result)
    );

endmodule

// ===== dv/nrte_line_checker.sv =====
// ----------------------------------------------------------------------------
// RMC line checker
// Watches the character, result and offset ports of the time extractor. It
// keeps its own copy of the sentence parser, queues the verdict and held time
// due at every line end and compares each result beat with the oldest entry.
// ----------------------------------------------------------------------------
module nrte_line_checker
    import nrte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    nrte_in_if         sentence,
    nrte_out_if        result,
    output int         failures,
    output int         outstanding,
    output int         reports_seen,
    output int         accepted_lines
);

    localparam logic [55:0] RMC_HEADER = "$GPRMC,";

    typedef enum logic [1:0] {
        SUM_BODY,
        SUM_HIGH,
        SUM_LOW,
        SUM_DONE
    } sum_phase_t;

    logic [4:0] zone_hours;
    logic [4:0] char_pos;
    logic       hdr_ok;
    logic       status_seen;
    logic       time_ok;
    logic       held_valid;
    logic [7:0] xor_acc;
    logic [7:0] rx_sum;
    sum_phase_t sum_phase;
    logic [3:0] line_digits [TIME_DIGITS];
    logic [3:0] held_digits [TIME_DIGITS];
    result_t    due_reports [$];

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return 4'(c - CHAR_ZERO);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        return 4'd0;
    endfunction

    function automatic void start_line();
        char_pos    = '0;
        hdr_ok      = 1'b1;
        xor_acc     = '0;
        sum_phase   = SUM_BODY;
        rx_sum      = '0;
        status_seen = 1'b0;
        time_ok     = 1'b1;
        for (int i = 0; i < TIME_DIGITS; i++)
            line_digits[i] = '0;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic eol);
        result_t    due;
        logic       ok;
        int         hour;
        if (char_pos < HEADER_LEN && c != RMC_HEADER[8 * (HEADER_LEN - 1 - char_pos) +: 8])
            hdr_ok = 1'b0;
        if (char_pos != 0) begin
            case (sum_phase)
                SUM_BODY:
                begin
                    if (c == CHAR_STAR)
                        sum_phase = SUM_HIGH;
                    else
                        xor_acc ^= c;
                end
                SUM_HIGH:
                begin
                    rx_sum    = {nibble_of(c), 4'd0};
                    sum_phase = SUM_LOW;
                end
                SUM_LOW:
                begin
                    rx_sum    = rx_sum + 8'(nibble_of(c));
                    sum_phase = SUM_DONE;
                end
                default:
                begin
                end
            endcase
        end
        if (char_pos >= TIME_FIRST && char_pos < TIME_FIRST + TIME_DIGITS) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                line_digits[char_pos - TIME_FIRST] = 4'(c - CHAR_ZERO);
            else
                time_ok = 1'b0;
        end
        if (char_pos == STATUS_POS && c == CHAR_ACTIVE)
            status_seen = 1'b1;
        if (char_pos != POS_MAX)
            char_pos = char_pos + 5'd1;
        if (eol) begin
            ok = hdr_ok && (xor_acc == rx_sum) && status_seen && time_ok;
            if (ok) begin
                for (int i = 0; i < TIME_DIGITS; i++)
                    held_digits[i] = line_digits[i];
                held_valid = 1'b1;
                accepted_lines++;
            end
            hour = int'(held_digits[0]) * 10 + int'(held_digits[1]) + int'(zone_hours);
            due.sentence_accepted = ok;
            due.time_known        = held_valid;
            due.local_hour        = 5'(hour % 24);
            due.minute_out        = 7'(int'(held_digits[2]) * 10 + int'(held_digits[3]));
            due.second_out        = 7'(int'(held_digits[4]) * 10 + int'(held_digits[5]));
            due_reports.push_back(due);
            start_line();
        end
    endtask

    task automatic check_report();
        result_t due;
        logic    bad;
        reports_seen++;
        if (due_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("Result beat %0d arrived with no line end pending", reports_seen);
        end
        else begin
            due = due_reports.pop_front();
            bad = (result.sentence_accepted !== due.sentence_accepted) ||
                  (result.time_known !== due.time_known) ||
                  (result.local_hour !== due.local_hour) ||
                  (result.minute_out !== due.minute_out) ||
                  (result.second_out !== due.second_out);
            if (bad) begin
                failures++;
                if (failures <= 10)
                    $display("Result beat %0d: expected acc=%0b known=%0b %0d:%0d:%0d, got acc=%0b known=%0b %0d:%0d:%0d",
                             reports_seen, due.sentence_accepted, due.time_known,
                             due.local_hour, due.minute_out, due.second_out,
                             result.sentence_accepted, result.time_known,
                             result.local_hour, result.minute_out, result.second_out);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            zone_hours = ZONE_RESET;
            start_line();
            for (int i = 0; i < TIME_DIGITS; i++)
                held_digits[i] = '0;
            held_valid     = 1'b0;
            due_reports.delete();
            failures       = 0;
            reports_seen   = 0;
            accepted_lines = 0;
            outstanding    = 0;
        end
        else begin
            if (result.valid === 1'b1 && result.ready === 1'b1)
                check_report();
            if (sentence.valid === 1'b1 && sentence.ready === 1'b1)
                parse_char(sentence.char_in, sentence.end_of_line);
            if (cfg_we)
                zone_hours = cfg_wdata;
            outstanding = due_reports.size();
        end
    end

endmodule

// ===== dv/nmea_rmc_time_extractor_test.sv =====
// ----------------------------------------------------------------------------
// RMC time extractor testbench
// Feeds well-formed and damaged RMC sentences, noise and short lines through
// the character channel under random gaps, stalls and offset settings; the
// line checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module nmea_rmc_time_extractor_test;

    localparam int TARGET_CHARS = 1100;
    localparam int BATCH_CHARS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum {
        LINE_GOOD,
        LINE_BAD_HEADER,
        LINE_BAD_TIME,
        LINE_VOID,
        LINE_BAD_SUM,
        LINE_ODD_SUM_DIGIT,
        LINE_NO_STAR,
        LINE_NO_STAR_ZERO,
        LINE_SHORT,
        LINE_LONG,
        LINE_NOISE
    } line_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       hold_req;
    logic       hold_ack;
    bit         no_gaps = 1'b0;
    logic [7:0] line_buf [$];
    int         chars_sent = 0;
    int         lines_sent = 0;
    int         zones_written = 0;
    int         failures;
    int         outstanding;
    int         reports_seen;
    int         accepted_lines;

    nrte_in_if  sentence ();
    nrte_out_if result ();

    nmea_rmc_time_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sentence  (sentence),
        .result    (result)
    );

    nrte_line_checker line_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .sentence       (sentence),
        .result         (result),
        .failures       (failures),
        .outstanding    (outstanding),
        .reports_seen   (reports_seen),
        .accepted_lines (accepted_lines)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // A change of hold_req asks for one long stretch with the result side held off.
    initial
    begin
        result.ready <= 1'b0;
        hold_ack     <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req !== hold_ack)
            begin
                result.ready <= 1'b0;
                hold_ack     <= hold_req;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                result.ready <= !(!no_gaps && $urandom_range(99) < 12);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eol);
        while (!no_gaps && $urandom_range(99) < 12)
        begin
            sentence.valid <= 1'b0;
            @(posedge clk);
        end
        sentence.valid       <= 1'b1;
        sentence.char_in     <= c;
        sentence.end_of_line <= eol;
        @(posedge clk);
        while (sentence.ready !== 1'b1)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
        lines_sent++;
        line_buf.delete();
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10)
            return 8'(nrte_pkg::CHAR_ZERO + n);
        return upper ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'(nrte_pkg::CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic void build_line(input line_kind_t kind, input string hhmmss);
        string      odd_digits;
        logic [7:0] sum;
        logic [7:0] c;
        int         n;
        int         k;
        bit         upper;
        odd_digits = "*G/:@`g~ ";
        line_buf.delete();
        if (kind == LINE_NOISE)
        begin
            n = $urandom_range(1, 30);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_text("$GPRMC,");
        if (hhmmss.len() == 6)
            push_text(hhmmss);
        else
            repeat (6) line_buf.push_back(random_digit());
        push_text(".");
        repeat (3) line_buf.push_back(random_digit());
        push_text(",");
        if (kind == LINE_VOID)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                c = "V";
            end
            else
            begin
                do c = 8'($urandom_range(0, 255)); while (c == nrte_pkg::CHAR_ACTIVE);
            end
            line_buf.push_back(c);
        end
        else
        begin
            line_buf.push_back(nrte_pkg::CHAR_ACTIVE);
        end
        n = (kind == LINE_LONG) ? $urandom_range(14, 30) : $urandom_range(0, 8);
        repeat (n)
        begin
            do
            begin
                if ($urandom_range(0, 9) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'($urandom_range(32, 126));
            end while (c == nrte_pkg::CHAR_STAR);
            line_buf.push_back(c);
        end
        if (kind == LINE_BAD_HEADER)
        begin
            k = $urandom_range(0, 6);
            do c = 8'($urandom_range(0, 255)); while (c == line_buf[k]);
            line_buf[k] = c;
        end
        if (kind == LINE_BAD_TIME)
        begin
            k = $urandom_range(7, 12);
            do c = 8'($urandom_range(0, 255));
            while (c >= nrte_pkg::CHAR_ZERO && c <= nrte_pkg::CHAR_NINE);
            line_buf[k] = c;
        end
        sum = '0;
        for (int i = 1; i < line_buf.size(); i++)
            sum ^= line_buf[i];
        if (kind == LINE_SHORT)
        begin
            n = $urandom_range(1, 18);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
            return;
        end
        if (kind == LINE_NO_STAR || kind == LINE_NO_STAR_ZERO)
        begin
            if (kind == LINE_NO_STAR_ZERO && sum != nrte_pkg::CHAR_STAR)
                line_buf.push_back(sum);
            return;
        end
        if (kind == LINE_BAD_SUM)
            sum ^= 8'($urandom_range(1, 255));
        line_buf.push_back(nrte_pkg::CHAR_STAR);
        upper = 1'($urandom_range(0, 1));
        line_buf.push_back(hex_char(sum[7:4], upper));
        line_buf.push_back(hex_char(sum[3:0], upper));
        if (kind == LINE_ODD_SUM_DIGIT)
        begin
            k = line_buf.size() - 1 - $urandom_range(0, 1);
            line_buf[k] = odd_digits[$urandom_range(0, odd_digits.len() - 1)];
        end
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic line_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 65) return LINE_GOOD;
        if (r < 69) return LINE_BAD_HEADER;
        if (r < 73) return LINE_BAD_TIME;
        if (r < 77) return LINE_VOID;
        if (r < 81) return LINE_BAD_SUM;
        if (r < 85) return LINE_ODD_SUM_DIGIT;
        if (r < 88) return LINE_NO_STAR;
        if (r < 91) return LINE_NO_STAR_ZERO;
        if (r < 94) return LINE_SHORT;
        if (r < 97) return LINE_LONG;
        return LINE_NOISE;
    endfunction

    task automatic wait_drained();
        sentence.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_zone(input logic [4:0] hours);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= hours;
        @(posedge clk);
        cfg_we    <= 1'b0;
        zones_written++;
    endtask

    task automatic run_batch(input int n);
        int first;
        first = chars_sent;
        while (chars_sent - first < n)
        begin
            build_line(pick_kind(), "");
            send_line();
        end
    endtask

    initial
    begin
        int phase;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        hold_req             <= 1'b0;
        sentence.valid       <= 1'b0;
        sentence.char_in     <= '0;
        sentence.end_of_line <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        line_buf.push_back(8'hFF);
        send_line();
        build_line(LINE_VOID, "123456");
        send_line();
        build_line(LINE_GOOD, "235959");
        send_line();
        build_line(LINE_BAD_TIME, "");
        send_line();
        build_line(LINE_BAD_HEADER, "");
        send_line();
        build_line(LINE_BAD_SUM, "");
        send_line();
        build_line(LINE_NO_STAR, "");
        send_line();
        build_line(LINE_NO_STAR_ZERO, "000000");
        send_line();
        build_line(LINE_ODD_SUM_DIGIT, "");
        send_line();
        build_line(LINE_SHORT, "");
        send_line();
        build_line(LINE_LONG, "999999");
        send_line();
        build_line(LINE_GOOD, "000000");
        send_line();
        build_line(LINE_NOISE, "");
        send_line();

        phase = 0;
        while (chars_sent < TARGET_CHARS)
        begin
            case (phase)
                0:       write_zone(5'd0);
                1:       write_zone(5'd31);
                2:       write_zone(5'd23);
                default: write_zone(5'($urandom_range(0, 31)));
            endcase
            if (phase == 2)
            begin
                hold_req <= !hold_req;
                repeat (12)
                begin
                    line_buf.push_back(8'($urandom_range(0, 255)));
                    send_line();
                end
            end
            no_gaps = (phase == 3);
            run_batch(BATCH_CHARS);
            no_gaps = 1'b0;
            phase++;
        end

        wait_drained();
        $display("Sent %0d characters in %0d lines; %0d results checked, %0d lines accepted.",
                 chars_sent, lines_sent, reports_seen, accepted_lines);
        $display("Zone offset written %0d times, including 0, 23 and 31.", zones_written);
        $display("One long output stall filled the block and held off the input.");
        if (failures == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/nrte_pkg.sv
hw/rtl/nrte_in_if.sv
hw/rtl/nrte_out_if.sv
hw/rtl/nrte_line_parser.sv
hw/rtl/nrte_result_buffer.sv
hw/rtl/nmea_rmc_time_extractor.sv
dv/nrte_line_checker.sv
dv/nmea_rmc_time_extractor_test.sv
